// File: rtl/afl_pkg.sv
// ----------------------------------------------------------------------------
// afl_pkg: shared types for the ALU with flags
// Opcode encoding, data width and the request and response payloads.
// ----------------------------------------------------------------------------
package afl_pkg;

  localparam int unsigned DataWidth = 8;

  typedef logic [DataWidth-1:0] afl_data_t;

  typedef enum logic [3:0] {
    FN_ADD   = 4'd0,
    FN_ADC   = 4'd1,
    FN_SUB   = 4'd2,
    FN_SBC   = 4'd3,
    FN_AND   = 4'd4,
    FN_OR    = 4'd5,
    FN_XOR   = 4'd6,
    FN_NEGA  = 4'd7,
    FN_NEGB  = 4'd8,
    FN_NOTA  = 4'd9,
    FN_NOTB  = 4'd10,
    FN_ASL   = 4'd11,
    FN_LSR   = 4'd12,
    FN_ROL   = 4'd13,
    FN_ROR   = 4'd14,
    FN_RESET = 4'd15
  } afl_func_e;

  typedef struct packed {
    afl_func_e func;
    afl_data_t opnd_a;
    afl_data_t opnd_b;
    afl_data_t accu_in;
    logic      zero_in;
    logic      sign_in;
    logic      carry_in;
    logic      ovf_in;
  } afl_req_t;

  typedef struct packed {
    afl_data_t accu_out;
    afl_data_t a_out;
    afl_data_t b_out;
    logic      zero_out;
    logic      sign_out;
    logic      carry_out;
    logic      ovf_out;
  } afl_rsp_t;

endpackage

// File: rtl/afl_req_if.sv
// ----------------------------------------------------------------------------
// afl_req_if: request channel of the ALU with flags
// Valid/ready channel carrying one instruction with its operands and flags.
// ----------------------------------------------------------------------------
interface afl_req_if;
  import afl_pkg::*;

  logic     valid;
  logic     ready;
  afl_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// File: rtl/afl_rsp_if.sv
// ----------------------------------------------------------------------------
// afl_rsp_if: response channel of the ALU with flags
// Valid/ready channel carrying the new accumulator, operands and flags.
// ----------------------------------------------------------------------------
interface afl_rsp_if;
  import afl_pkg::*;

  logic     valid;
  logic     ready;
  afl_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// File: rtl/alu_with_flags.sv
// ----------------------------------------------------------------------------
// alu_with_flags: 8-bit ALU with zero, sign, carry and overflow flags
//
//   channel  dir  payload                                   handshake
//   req_i    in   func, opnd_a, opnd_b, accu_in, Z S C V    valid/ready
//   rsp_o    out  accu_out, a_out, b_out, Z S C V           valid/ready
//
// One instruction per cycle sustained while the response is not stalled. The
// response is offered once the instruction has passed the input register, then
// the result register.
// The operation is a single 9-bit add, a negate/invert or a logic/shift select.
// Reset clears both valid bits; payload registers are not reset.
// A stalled response holds; the input register still takes one more
// instruction, and req_i.ready drops only when both registers are full.
// ----------------------------------------------------------------------------
module alu_with_flags
  import afl_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  afl_req_if.sink   req_i,
  afl_rsp_if.source rsp_o
);

  localparam int unsigned Msb = DataWidth - 1;

  logic     in_valid_q;
  afl_req_t in_data_q;
  logic     out_valid_q;
  afl_rsp_t out_data_q;
  afl_rsp_t out_data_d;

  logic out_ready;
  logic in_ready;

  assign out_ready   = !out_valid_q || rsp_o.ready;
  assign in_ready    = !in_valid_q || out_ready;
  assign req_i.ready = in_ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && req_i.valid) begin
      in_data_q <= req_i.data;
    end
  end

  // Operation
  afl_data_t      addend;
  logic           cin;
  logic [Msb+1:0] sum;

  always_comb begin
    addend = (in_data_q.func == FN_SUB || in_data_q.func == FN_SBC) ?
             ~in_data_q.opnd_b : in_data_q.opnd_b;
    case (in_data_q.func)
      FN_ADD:  cin = 1'b0;
      FN_SUB:  cin = 1'b1;
      default: cin = in_data_q.carry_in;
    endcase
    sum = {1'b0, in_data_q.opnd_a} + {1'b0, addend} + {{DataWidth{1'b0}}, cin};
  end

  always_comb begin
    out_data_d.accu_out  = in_data_q.accu_in;
    out_data_d.a_out     = in_data_q.opnd_a;
    out_data_d.b_out     = in_data_q.opnd_b;
    out_data_d.zero_out  = in_data_q.zero_in;
    out_data_d.sign_out  = in_data_q.sign_in;
    out_data_d.carry_out = in_data_q.carry_in;
    out_data_d.ovf_out   = in_data_q.ovf_in;
    unique case (in_data_q.func)
      FN_ADD, FN_ADC, FN_SUB, FN_SBC: begin
        out_data_d.accu_out  = sum[Msb:0];
        out_data_d.carry_out = sum[Msb+1];
        // same-sign addends giving a result of the other sign
        out_data_d.ovf_out   = (in_data_q.opnd_a[Msb] == addend[Msb]) &&
                               (addend[Msb] != sum[Msb]);
        out_data_d.zero_out  = (sum[Msb:0] == '0);
        out_data_d.sign_out  = sum[Msb];
      end
      FN_AND, FN_OR, FN_XOR: begin
        if (in_data_q.func == FN_AND) begin
          out_data_d.accu_out = in_data_q.opnd_a & in_data_q.opnd_b;
        end else if (in_data_q.func == FN_OR) begin
          out_data_d.accu_out = in_data_q.opnd_a | in_data_q.opnd_b;
        end else begin
          out_data_d.accu_out = in_data_q.opnd_a ^ in_data_q.opnd_b;
        end
        out_data_d.zero_out = (out_data_d.accu_out == '0);
        out_data_d.sign_out = out_data_d.accu_out[Msb];
      end
      FN_NEGA: out_data_d.a_out = ~in_data_q.opnd_a + afl_data_t'(1);
      FN_NEGB: out_data_d.b_out = ~in_data_q.opnd_b + afl_data_t'(1);
      FN_NOTA: out_data_d.a_out = ~in_data_q.opnd_a;
      FN_NOTB: out_data_d.b_out = ~in_data_q.opnd_b;
      FN_ASL: begin
        out_data_d.accu_out  = {in_data_q.opnd_a[Msb-1:0], 1'b0};
        out_data_d.carry_out = in_data_q.opnd_a[Msb];
      end
      FN_LSR: out_data_d.accu_out = {1'b0, in_data_q.opnd_a[Msb:1]};
      FN_ROL: begin
        out_data_d.accu_out  = {in_data_q.opnd_a[Msb-1:0], in_data_q.carry_in};
        out_data_d.carry_out = in_data_q.opnd_a[Msb];
      end
      FN_ROR: begin
        out_data_d.accu_out  = {in_data_q.carry_in, in_data_q.opnd_a[Msb:1]};
        out_data_d.carry_out = in_data_q.opnd_a[0];
      end
      FN_RESET: out_data_d = '0;
    endcase
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && in_valid_q) begin
      out_data_q <= out_data_d;
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_data_q;

endmodule

// File: rtl/afl_checker.sv
// ----------------------------------------------------------------------------
// afl_checker: port-level checks for the ALU with flags
// Watches both channels and the flow through the two register stages.
// ----------------------------------------------------------------------------
module afl_checker
  import afl_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     req_valid_i,
  input logic     req_ready_i,
  input logic     rsp_valid_i,
  input logic     rsp_ready_i,
  input afl_rsp_t rsp_data_i
);

  logic req_xfer;

  assign req_xfer = req_valid_i && req_ready_i;

  // a response stays offered until it is transferred
  a_rsp_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response withdrawn before transfer");

  a_rsp_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(rsp_data_i))
    else $error("stalled response changed");

  // back-pressure only when both stages are full and the output is stalled
  a_ready_low_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_ready_i |-> rsp_valid_i && !rsp_ready_i)
    else $error("request refused with room in the pipeline");

  // an idle output comes alive only after a request transfer has passed both stages
  a_rsp_from_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> $past(req_xfer, 2))
    else $error("response without a matching request");

endmodule

bind alu_with_flags afl_checker u_afl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_data_i  (rsp_o.data)
);

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for alu_with_flags
// Drives instructions over the request channel and predicts each response
// from its own model of the operation. Every response is compared field by
// field with the oldest prediction. Both sides idle in random bursts, with
// one long response stall and one pause until all responses have come back.
// ----------------------------------------------------------------------------
module tb;
  import afl_pkg::*;

  localparam int unsigned NumRandom = 1000;
  localparam int unsigned DrainAt   = 600;
  localparam int unsigned LongStall = 90;
  localparam int unsigned StallAt   = 300;
  localparam int unsigned CalmTail  = 120;

  logic clk;
  logic rst_n;

  afl_req_if req_if ();
  afl_rsp_if rsp_if ();

  alu_with_flags u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  afl_req_t    pending_instr_q[$];
  afl_rsp_t    expected_rsp_q[$];
  int unsigned n_total;
  int unsigned n_sent;
  int unsigned n_rcvd;
  int unsigned n_err;
  int unsigned send_gap;
  int unsigned recv_stall;
  bit          drain_done;
  bit          long_done;

  // Bit-accurate model of one ALU instruction.
  function automatic afl_rsp_t alu_predict(afl_req_t r);
    afl_rsp_t             o;
    afl_data_t            addend;
    logic [DataWidth:0]   sum9;
    logic                 cin;
    o.accu_out  = r.accu_in;
    o.a_out     = r.opnd_a;
    o.b_out     = r.opnd_b;
    o.zero_out  = r.zero_in;
    o.sign_out  = r.sign_in;
    o.carry_out = r.carry_in;
    o.ovf_out   = r.ovf_in;
    case (r.func)
      FN_ADD, FN_ADC, FN_SUB, FN_SBC: begin
        addend = (r.func == FN_SUB || r.func == FN_SBC) ? ~r.opnd_b : r.opnd_b;
        cin    = (r.func == FN_ADD) ? 1'b0 : (r.func == FN_SUB) ? 1'b1 : r.carry_in;
        sum9   = {1'b0, r.opnd_a} + {1'b0, addend} + {{DataWidth{1'b0}}, cin};
        o.accu_out  = sum9[DataWidth-1:0];
        o.carry_out = sum9[DataWidth];
        o.ovf_out   = (r.opnd_a[DataWidth-1] == addend[DataWidth-1]) &&
                      (addend[DataWidth-1] != sum9[DataWidth-1]);
        o.zero_out  = (sum9[DataWidth-1:0] == '0);
        o.sign_out  = sum9[DataWidth-1];
      end
      FN_AND, FN_OR, FN_XOR: begin
        o.accu_out = (r.func == FN_AND) ? (r.opnd_a & r.opnd_b) :
                     (r.func == FN_OR)  ? (r.opnd_a | r.opnd_b) :
                                          (r.opnd_a ^ r.opnd_b);
        o.zero_out = (o.accu_out == '0);
        o.sign_out = o.accu_out[DataWidth-1];
      end
      FN_NEGA: o.a_out = ~r.opnd_a + afl_data_t'(1);
      FN_NEGB: o.b_out = ~r.opnd_b + afl_data_t'(1);
      FN_NOTA: o.a_out = ~r.opnd_a;
      FN_NOTB: o.b_out = ~r.opnd_b;
      FN_ASL: begin
        o.accu_out  = {r.opnd_a[DataWidth-2:0], 1'b0};
        o.carry_out = r.opnd_a[DataWidth-1];
      end
      FN_LSR: o.accu_out = {1'b0, r.opnd_a[DataWidth-1:1]};
      FN_ROL: begin
        o.accu_out  = {r.opnd_a[DataWidth-2:0], r.carry_in};
        o.carry_out = r.opnd_a[DataWidth-1];
      end
      FN_ROR: begin
        o.accu_out  = {r.carry_in, r.opnd_a[DataWidth-1:1]};
        o.carry_out = r.opnd_a[0];
      end
      default: o = '0;
    endcase
    return o;
  endfunction

  function automatic afl_req_t make_instr(afl_func_e f, afl_data_t a, afl_data_t b,
                                          afl_data_t acc, logic [3:0] zscv);
    afl_req_t r;
    r.func     = f;
    r.opnd_a   = a;
    r.opnd_b   = b;
    r.accu_in  = acc;
    r.zero_in  = zscv[3];
    r.sign_in  = zscv[2];
    r.carry_in = zscv[1];
    r.ovf_in   = zscv[0];
    return r;
  endfunction

  // Bias some operands towards the edges of the range.
  function automatic afl_data_t pick_operand();
    afl_data_t edges[5];
    edges = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFF};
    if ($urandom_range(0, 3) == 0) return edges[$urandom_range(0, 4)];
    return afl_data_t'($urandom);
  endfunction

  task automatic check_field(string name, logic [DataWidth-1:0] exp_v,
                             logic [DataWidth-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      n_err++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Request side: push a prediction on each transfer, then offer the next item.
  always @(posedge clk) begin
    if (rst_n) begin
      if (req_if.valid && req_if.ready) begin
        expected_rsp_q.push_back(alu_predict(req_if.data));
        n_sent++;
        if (n_sent + CalmTail < n_total && (n_sent % 200) < 160 &&
            $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(1, 18);
        end
      end
      if (!req_if.valid || req_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          req_if.valid <= 1'b0;
        end else if (n_sent == DrainAt && !drain_done) begin
          // hold off until every outstanding response is back
          if (expected_rsp_q.size() == 0) drain_done = 1'b1;
          req_if.valid <= 1'b0;
        end else if (pending_instr_q.size() > 0) begin
          req_if.valid <= 1'b1;
          req_if.data  <= pending_instr_q.pop_front();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Response side: check each transfer, then decide whether to stall.
  always @(posedge clk) begin
    afl_rsp_t exp_r;
    afl_rsp_t act_r;
    if (rst_n) begin
      if (rsp_if.valid && rsp_if.ready) begin
        act_r = rsp_if.data;
        n_rcvd++;
        if (expected_rsp_q.size() == 0) begin
          $display("%0t: response with none outstanding, expected none, actual %h",
                   $time, act_r);
          n_err++;
        end else begin
          exp_r = expected_rsp_q.pop_front();
          check_field("accu_out", exp_r.accu_out, act_r.accu_out);
          check_field("a_out", exp_r.a_out, act_r.a_out);
          check_field("b_out", exp_r.b_out, act_r.b_out);
          check_field("zero_out", afl_data_t'(exp_r.zero_out),
                      afl_data_t'(act_r.zero_out));
          check_field("sign_out", afl_data_t'(exp_r.sign_out),
                      afl_data_t'(act_r.sign_out));
          check_field("carry_out", afl_data_t'(exp_r.carry_out),
                      afl_data_t'(act_r.carry_out));
          check_field("ovf_out", afl_data_t'(exp_r.ovf_out),
                      afl_data_t'(act_r.ovf_out));
        end
      end
      if (n_rcvd >= StallAt && !long_done) begin
        // long stall so the block fills and drops its input ready
        long_done  = 1'b1;
        recv_stall = LongStall;
      end
      if (recv_stall > 0) begin
        recv_stall--;
        rsp_if.ready <= 1'b0;
      end else if (n_rcvd + CalmTail < n_total && (n_rcvd % 200) < 160 &&
                   $urandom_range(0, 7) == 0) begin
        recv_stall = $urandom_range(1, 18) - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    afl_req_t r;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;
    rst_n        = 1'b0;
    n_sent       = 0;
    n_rcvd       = 0;
    n_err        = 0;
    send_gap     = 0;
    recv_stall   = 0;
    drain_done   = 1'b0;
    long_done    = 1'b0;

    // signed overflow, carry out with zero result, carry in
    pending_instr_q.push_back(make_instr(FN_ADD, 8'h7F, 8'h01, 8'h5A, 4'b0000));
    pending_instr_q.push_back(make_instr(FN_ADD, 8'hFF, 8'h01, 8'hA5, 4'b0000));
    pending_instr_q.push_back(make_instr(FN_ADD, 8'h80, 8'h80, 8'h00, 4'b1111));
    pending_instr_q.push_back(make_instr(FN_ADC, 8'hFF, 8'h00, 8'h00, 4'b0010));
    pending_instr_q.push_back(make_instr(FN_ADC, 8'h7F, 8'h7F, 8'hFF, 4'b1111));
    // subtract: equal operands, borrow, overflow, carry in clear
    pending_instr_q.push_back(make_instr(FN_SUB, 8'h42, 8'h42, 8'h00, 4'b0000));
    pending_instr_q.push_back(make_instr(FN_SUB, 8'h00, 8'h01, 8'h00, 4'b0000));
    pending_instr_q.push_back(make_instr(FN_SUB, 8'h80, 8'h01, 8'hFF, 4'b1111));
    pending_instr_q.push_back(make_instr(FN_SBC, 8'h10, 8'h10, 8'h00, 4'b0000));
    pending_instr_q.push_back(make_instr(FN_SBC, 8'h7F, 8'hFF, 8'h00, 4'b0010));
    // logic results that hit zero and the sign bit
    pending_instr_q.push_back(make_instr(FN_AND, 8'hAA, 8'h55, 8'hFF, 4'b0111));
    pending_instr_q.push_back(make_instr(FN_OR, 8'h80, 8'h00, 8'h00, 4'b1011));
    pending_instr_q.push_back(make_instr(FN_XOR, 8'hFF, 8'hFF, 8'h12, 4'b0101));
    // in-place negate and invert, including the most negative value
    pending_instr_q.push_back(make_instr(FN_NEGA, 8'h80, 8'h33, 8'h44, 4'b1010));
    pending_instr_q.push_back(make_instr(FN_NEGA, 8'h00, 8'hFF, 8'hFF, 4'b0101));
    pending_instr_q.push_back(make_instr(FN_NEGB, 8'h11, 8'h00, 8'h22, 4'b1111));
    pending_instr_q.push_back(make_instr(FN_NEGB, 8'hFF, 8'h01, 8'h00, 4'b0000));
    pending_instr_q.push_back(make_instr(FN_NOTA, 8'h00, 8'hFF, 8'h80, 4'b0110));
    pending_instr_q.push_back(make_instr(FN_NOTB, 8'hFF, 8'h5A, 8'h01, 4'b1001));
    // shifts and rotates through carry
    pending_instr_q.push_back(make_instr(FN_ASL, 8'h80, 8'h00, 8'h00, 4'b1101));
    pending_instr_q.push_back(make_instr(FN_LSR, 8'h01, 8'hFF, 8'hFF, 4'b1111));
    pending_instr_q.push_back(make_instr(FN_ROL, 8'h80, 8'h00, 8'h00, 4'b0010));
    pending_instr_q.push_back(make_instr(FN_ROR, 8'h01, 8'h00, 8'h00, 4'b0010));
    pending_instr_q.push_back(make_instr(FN_ROR, 8'hFE, 8'h00, 8'hFF, 4'b1101));
    pending_instr_q.push_back(make_instr(FN_RESET, 8'hFF, 8'hFF, 8'hFF, 4'b1111));

    for (int i = 0; i < NumRandom; i++) begin
      r = make_instr(afl_func_e'($urandom_range(0, 15)), pick_operand(), pick_operand(),
                     afl_data_t'($urandom), 4'($urandom));
      pending_instr_q.push_back(r);
    end
    n_total = pending_instr_q.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (!(n_sent == n_total && expected_rsp_q.size() == 0)) @(posedge clk);
    repeat (8) @(posedge clk);
    if (expected_rsp_q.size() != 0) begin
      $display("%0t: responses missing, expected 0 outstanding, actual %0d",
               $time, expected_rsp_q.size());
      n_err++;
    end
    if (n_err == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule

// File: filelist.f
rtl/afl_pkg.sv
rtl/afl_req_if.sv
rtl/afl_rsp_if.sv
rtl/alu_with_flags.sv
rtl/afl_checker.sv
bench/tb.sv
